FILE: sv/cmd_pkg.sv
// Shared types and constants for the compressed mail deframer.
package cmd_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int LEN_BITS       = 24;
  localparam int BYTE_BITS      = 8;
  localparam int FRAME_BITS     = 9;

  localparam logic [BYTE_BITS-1:0] CH_NUL = 8'd0;
  localparam logic [BYTE_BITS-1:0] CH_SOH = 8'd1;
  localparam logic [BYTE_BITS-1:0] CH_STX = 8'd2;
  localparam logic [BYTE_BITS-1:0] CH_EOT = 8'd4;

  localparam logic [FRAME_BITS-1:0] FRAME_FULL = 9'd256;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'd0,
    PH_HDRLEN = 4'd1,
    PH_TITLE  = 4'd2,
    PH_OFFSET = 4'd3,
    PH_FRAME  = 4'd4,
    PH_FLEN   = 4'd5,
    PH_DATA   = 4'd6,
    PH_CHKSUM = 4'd7
  } phase_t;

  typedef enum logic [2:0] {
    K_TITLE  = 3'd0,
    K_OFFSET = 3'd1,
    K_DATA   = 3'd2,
    K_OK     = 3'd3,
    K_CSUM   = 3'd4,
    K_FORMAT = 3'd5,
    K_ABORT  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] in_byte;
    logic                 abort;
  } item_t;

  typedef struct packed {
    kind_t                out_kind;
    logic [BYTE_BITS-1:0] out_byte;
    logic [LEN_BITS-1:0]  msg_length;
  } result_t;

endpackage

FILE: sv/compressed_mail_deframer.sv
// Top level of the compressed mail deframer: input register, step logic, result register.
//
//   Channel  Dir  Handshake           Payload
//   s_*      in   s_tvalid/s_tready   s_tdata = in_byte, s_tuser = abort
//   m_*      out  m_tvalid/m_tready   m_tdata = out_byte, msg_length; m_tuser = out_kind
//
// One item is accepted per cycle while s_tready is high; an item's result, if any, passes
// from the input register through the step logic into the result register onto m_tvalid.
// Reset (rst, synchronous) empties both registers and returns to waiting for SOH.
// While a result waits on m_tready, one more item can be taken into the input
// register; s_tready drops only when both registers are full and m_tready is low.
module compressed_mail_deframer #(
  parameter int COUNT_BITS = cmd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] abort
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [31:8] msg_length
  output logic [2:0]  m_tuser    // [2:0] out_kind
);
  import cmd_pkg::*;

  item_t   s_item;
  item_t   item;
  logic    in_vld;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t m_res;

  assign s_item.in_byte = s_tdata;
  assign s_item.abort   = s_tuser;

  cmd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_item  (s_item),
    .advance (advance),
    .vld     (in_vld),
    .item    (item)
  );

  cmd_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  cmd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (in_vld),
    .res_valid (res_valid),
    .res       (res),
    .m_ready   (m_tready),
    .advance   (advance),
    .m_valid   (m_tvalid),
    .m_res     (m_res)
  );

  assign m_tdata = {m_res.msg_length, m_res.out_byte};
  assign m_tuser = m_res.out_kind;

endmodule

FILE: sv/cmd_in_stage.sv
// Input register that holds one received item until the step logic takes it.
module cmd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  cmd_pkg::item_t s_item,
  input  logic           advance,
  output logic           vld,
  output cmd_pkg::item_t item
);
  import cmd_pkg::*;

  assign s_ready = !vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_valid && s_ready) begin
      vld <= 1'b1;
    end else if (advance) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

FILE: sv/cmd_step.sv
// Message state machine: consumes one byte per step and forms at most one result.
module cmd_step #(
  parameter int COUNT_BITS = cmd_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  cmd_pkg::item_t   item,
  output logic             res_valid,
  output cmd_pkg::result_t res
);
  import cmd_pkg::*;

  phase_t                  phase, phase_next;
  logic [BYTE_BITS-1:0]    running_sum, running_sum_next;
  logic [FRAME_BITS-1:0]   frame_left, frame_left_next;
  logic [COUNT_BITS-1:0]   data_count, data_count_next;
  logic [BYTE_BITS-1:0]    sum_add;
  logic [FRAME_BITS-1:0]   frame_dec;
  logic [COUNT_BITS-1:0]   count_inc;
  logic [LEN_BITS-1:0]     len_view;

  assign sum_add   = running_sum + item.in_byte;
  assign frame_dec = frame_left - FRAME_BITS'(1);
  assign count_inc = (&data_count) ? data_count : data_count + COUNT_BITS'(1);

  // The reported length is the count before the update, except for a data
  // byte, which reports the count including itself. An abort in the data
  // phase counts nothing.
  generate
    if (COUNT_BITS >= LEN_BITS) begin : g_len_trunc
      assign len_view = ((phase == PH_DATA) && !item.abort) ? count_inc[LEN_BITS-1:0]
                                                            : data_count[LEN_BITS-1:0];
    end else begin : g_len_ext
      assign len_view = ((phase == PH_DATA) && !item.abort) ? LEN_BITS'(count_inc)
                                                            : LEN_BITS'(data_count);
    end
  endgenerate

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (item.abort) begin
      phase_next = PH_WAIT;
    end else begin
      case (phase)
        PH_WAIT: begin
          if (item.in_byte == CH_SOH) phase_next = PH_HDRLEN;
        end
        PH_HDRLEN: phase_next = PH_TITLE;
        PH_TITLE: begin
          if (item.in_byte == CH_NUL) phase_next = PH_OFFSET;
        end
        PH_OFFSET: begin
          if (item.in_byte == CH_NUL) phase_next = PH_FRAME;
        end
        PH_FRAME: begin
          if (item.in_byte == CH_STX) begin
            phase_next = PH_FLEN;
          end else if (item.in_byte == CH_EOT) begin
            phase_next = PH_CHKSUM;
          end else begin
            phase_next = PH_WAIT;
          end
        end
        PH_FLEN: phase_next = PH_DATA;
        PH_DATA: begin
          if (frame_dec == '0) phase_next = PH_FRAME;
        end
        PH_CHKSUM: phase_next = PH_WAIT;
        default: phase_next = PH_WAIT;
      endcase
    end
  end

  // Datapath updates and the result.
  always_comb begin
    running_sum_next = running_sum;
    frame_left_next  = frame_left;
    data_count_next  = data_count;
    res_valid        = 1'b0;
    res.out_kind     = K_FORMAT;
    res.out_byte     = '0;
    res.msg_length   = len_view;
    if (item.abort) begin
      res_valid    = (phase != PH_WAIT);
      res.out_kind = K_ABORT;
    end else begin
      case (phase)
        PH_WAIT: begin
          if (item.in_byte == CH_SOH) begin
            running_sum_next = '0;
            frame_left_next  = '0;
            data_count_next  = '0;
          end else begin
            res_valid    = 1'b1;
            res.out_kind = K_FORMAT;
          end
        end
        PH_TITLE: begin
          res_valid    = (item.in_byte != CH_NUL);
          res.out_kind = K_TITLE;
          res.out_byte = item.in_byte;
        end
        PH_OFFSET: begin
          res_valid    = (item.in_byte != CH_NUL);
          res.out_kind = K_OFFSET;
          res.out_byte = item.in_byte;
        end
        PH_FRAME: begin
          res_valid    = (item.in_byte != CH_STX) && (item.in_byte != CH_EOT);
          res.out_kind = K_FORMAT;
        end
        PH_FLEN: begin
          frame_left_next = (item.in_byte == CH_NUL) ? FRAME_FULL
                                                     : FRAME_BITS'(item.in_byte);
        end
        PH_DATA: begin
          running_sum_next = sum_add;
          data_count_next  = count_inc;
          frame_left_next  = frame_dec;
          res_valid        = 1'b1;
          res.out_kind     = K_DATA;
          res.out_byte     = item.in_byte;
        end
        PH_CHKSUM: begin
          res_valid    = 1'b1;
          res.out_kind = (sum_add == '0) ? K_OK : K_CSUM;
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      running_sum <= '0;
      frame_left  <= '0;
      data_count  <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      frame_left  <= frame_left_next;
      data_count  <= data_count_next;
    end
  end

endmodule

FILE: sv/cmd_out_stage.sv
// Result register that holds one result until the downstream side takes it.
module cmd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic             res_valid,
  input  cmd_pkg::result_t res,
  input  logic             m_ready,
  output logic             advance,
  output logic             m_valid,
  output cmd_pkg::result_t m_res
);
  import cmd_pkg::*;

  // A held item moves through the step logic when the result slot is free
  // or is emptied in this same cycle.
  assign advance = in_vld && (!m_valid || m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= res_valid;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_res <= res;
    end
  end

endmodule
